// ===== rtl/hpm_pkg.sv =====
package hpm_pkg;

  // Default number of node slots in the cell chain.
  localparam int NODE_SLOTS_DEF = 5;

  // Number of node address registers.
  localparam int ADDR_REGS = 5;

  // Field widths.
  localparam int ADDR_W    = 8;
  localparam int TIME_W    = 32;
  localparam int TMO_W     = 16;
  localparam int NCNT_W    = 3;
  localparam int NIDX_W    = 3;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Request opcodes.
  localparam logic OP_RECV  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Event kinds on the result channel.
  localparam logic [KIND_W-1:0] KIND_ONLINE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOST   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALL    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_NODE0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_NODE4   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_NODES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [NCNT_W-1:0] ACTIVE_NODES_RST = 3'd5;
  localparam logic [TMO_W-1:0]  LOST_TIMEOUT_RST = 16'd2000;

  // Pending event held in each cell of the chain.
  typedef enum logic [1:0] {
    EV_NONE,
    EV_ON,
    EV_LOST
  } hpm_ev_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } hpm_state_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              recv_en;
    logic              check_en;
    logic              shift_en;
    logic [ADDR_W-1:0] src_addr;
    logic [TIME_W-1:0] now_ms;
    logic [TMO_W-1:0]  timeout;
  } hpm_cell_ctl_t;

endpackage

// ===== rtl/hpm_ifs.sv =====
// Input request channel.
interface hpm_in_if;
  import hpm_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] src_addr;
  logic [TIME_W-1:0] now_ms;
  modport source (output valid, output op, output src_addr, output now_ms, input ready);
  modport sink   (input valid, input op, input src_addr, input now_ms, output ready);
endinterface

// Result event channel.
interface hpm_out_if;
  import hpm_pkg::*;
  logic              valid;
  logic              ready;
  logic [NIDX_W-1:0] node_index;
  logic [KIND_W-1:0] event_kind;
  logic              last_event;
  modport source (output valid, output node_index, output event_kind, output last_event,
                  input ready);
  modport sink   (input valid, input node_index, input event_kind, input last_event,
                  output ready);
endinterface

// Configuration write channel.
interface hpm_cfg_if;
  import hpm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/hpm_cell.sv =====
module hpm_cell import hpm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  hpm_cell_ctl_t     ctl,
  input  logic              act,
  input  logic [ADDR_W-1:0] addr,
  input  logic              taken_in,
  output logic              taken_out,
  input  hpm_ev_t           ev_in,
  output hpm_ev_t           ev_out,
  output logic              online
);

  logic [TIME_W-1:0] last_seen_r;
  logic              online_r;
  hpm_ev_t           ev_r;

  logic              hit;
  logic              wr_seen;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] tmo_ext;
  logic              go_on;
  logic              go_lost;

  // Address match; a lower cell that already matched takes the message.
  assign hit       = act && (addr == ctl.src_addr);
  assign wr_seen   = ctl.recv_en && hit && !taken_in;
  assign taken_out = taken_in || hit;

  // Liveness decision of this node against the timeout.
  assign elapsed = ctl.now_ms - last_seen_r;
  assign tmo_ext = {{(TIME_W-TMO_W){1'b0}}, ctl.timeout};
  assign go_on   = act && !online_r && (elapsed < tmo_ext) && (last_seen_r != '0);
  assign go_lost = act && online_r && (elapsed > tmo_ext);

  // Last-seen time of the node.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seen_r <= '0;
    end else if (wr_seen) begin
      last_seen_r <= ctl.now_ms;
    end
  end

  // Online flag and the pending event, which shifts toward cell 0 during a scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r <= 1'b0;
      ev_r     <= EV_NONE;
    end else if (ctl.check_en) begin
      if (go_on) begin
        online_r <= 1'b1;
        ev_r     <= EV_ON;
      end else if (go_lost) begin
        online_r <= 1'b0;
        ev_r     <= EV_LOST;
      end else begin
        ev_r     <= EV_NONE;
      end
    end else if (ctl.shift_en) begin
      ev_r <= ev_in;
    end
  end

  assign ev_out = ev_r;
  assign online = online_r;

endmodule

// ===== rtl/node_heartbeat_presence_monitor.sv =====
// Heartbeat presence monitor for up to five nodes, built as a chain of node cells.
// On a receive request (op 0) the cells compare the source address
// with their configured address, the lowest active match stores now_ms, and an
// unmatched address is dropped. A check request (op 1) decides every active node
// in its accept cycle, then the pending events shift one cell per cycle toward
// the head of the chain (holding while the result channel stalls an event at the
// head), where they are sent out in node order. An all-online event follows the
// online event that completes the set. No new request is taken until the scan
// is done. The last event of a check carries last_event. Configuration writes
// are taken in any cycle and must be made while the block is idle.
module node_heartbeat_presence_monitor import hpm_pkg::*; #(
  parameter int NODE_SLOTS = NODE_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hpm_in_if.sink     in_ch,
  hpm_out_if.source  out_ch,
  hpm_cfg_if.sink    cfg_ch
);

  localparam int MAX_NODES = (NODE_SLOTS < ADDR_REGS) ? NODE_SLOTS : ADDR_REGS;
  localparam int CNT_W     = $clog2(NODE_SLOTS + 1);
  localparam int IDX_W     = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;

  // Configuration registers.
  logic [ADDR_W-1:0] addr_r [ADDR_REGS];
  logic [NCNT_W-1:0] active_nodes_r;
  logic [TMO_W-1:0]  timeout_r;

  // Sequencer state.
  hpm_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;

  // Output register.
  logic              out_valid_r;
  logic [NIDX_W-1:0] out_idx_r;
  logic [KIND_W-1:0] out_kind_r;
  logic              out_last_r;

  logic              emit;
  logic [NIDX_W-1:0] emit_idx;
  logic [KIND_W-1:0] emit_kind;
  logic              emit_last;

  logic              in_acc;
  logic              check_acc;
  logic              load_ok;
  logic              shift;
  logic [NCNT_W-1:0] node_cnt;
  logic [CNT_W-1:0]  node_cnt_ext;
  logic [CNT_W-1:0]  online_cnt;
  logic              any_ev;
  logic              later_ev;

  hpm_cell_ctl_t     ctl;
  logic [NODE_SLOTS-1:0] act;
  logic [NODE_SLOTS-1:0] online;
  logic [NODE_SLOTS-1:0] evbits;
  logic [NODE_SLOTS:0]   taken;
  hpm_ev_t               ev [NODE_SLOTS+1];

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign check_acc = in_acc && (in_ch.op == OP_CHECK);
  assign load_ok   = !out_valid_r || out_ch.ready;

  // Configuration writes.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ADDR_REGS; i++) begin
        addr_r[i] <= ADDR_W'(i);
      end
      active_nodes_r <= ACTIVE_NODES_RST;
      timeout_r      <= LOST_TIMEOUT_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index <= REG_ADDR_NODE4) begin
        addr_r[cfg_ch.index] <= cfg_ch.data[ADDR_W-1:0];
      end else if (cfg_ch.index == REG_ACTIVE_NODES) begin
        active_nodes_r <= cfg_ch.data[NCNT_W-1:0];
      end else if (cfg_ch.index == REG_LOST_TIMEOUT) begin
        timeout_r <= cfg_ch.data[TMO_W-1:0];
      end
    end
  end

  // Monitored node count, clamped to the available slots.
  always_comb begin
    if (active_nodes_r == '0) begin
      node_cnt = NCNT_W'(1);
    end else if (active_nodes_r > NCNT_W'(MAX_NODES)) begin
      node_cnt = NCNT_W'(MAX_NODES);
    end else begin
      node_cnt = active_nodes_r;
    end
  end
  assign node_cnt_ext = CNT_W'(node_cnt);

  // Broadcast controls for the cells.
  assign ctl.recv_en  = in_acc && (in_ch.op == OP_RECV);
  assign ctl.check_en = check_acc;
  assign ctl.shift_en = shift;
  assign ctl.src_addr = in_ch.src_addr;
  assign ctl.now_ms   = in_ch.now_ms;
  assign ctl.timeout  = timeout_r;

  // The cell chain.
  assign taken[0]        = 1'b0;
  assign ev[NODE_SLOTS]  = EV_NONE;

  for (genvar g = 0; g < NODE_SLOTS; g++) begin : g_cell
    logic [ADDR_W-1:0] cell_addr;

    if (g < MAX_NODES) begin : g_used
      assign act[g]    = (NCNT_W'(g) < node_cnt);
      assign cell_addr = addr_r[g];
    end else begin : g_spare
      assign act[g]    = 1'b0;
      assign cell_addr = '0;
    end

    hpm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .act       (act[g]),
      .addr      (cell_addr),
      .taken_in  (taken[g]),
      .taken_out (taken[g+1]),
      .ev_in     (ev[g+1]),
      .ev_out    (ev[g]),
      .online    (online[g])
    );

    assign evbits[g] = (ev[g] != EV_NONE);
  end

  assign any_ev   = |evbits;
  assign later_ev = |(evbits >> 1);

  // Online nodes among the monitored ones, taken at the start of a check.
  always_comb begin
    online_cnt = '0;
    for (int i = 0; i < NODE_SLOTS; i++) begin
      online_cnt = online_cnt + CNT_W'(online[i] && act[i]);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (check_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!pend_r && !any_ev) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Scan outputs: one event per cycle from the head cell while the result channel takes them.
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    shift       = 1'b0;
    emit        = 1'b0;
    emit_idx    = '0;
    emit_kind   = KIND_ONLINE;
    emit_last   = 1'b0;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    pend_nxt    = pend_r;
    unique case (state_r)
      ST_IDLE: begin
        if (check_acc) begin
          cnt_nxt  = online_cnt;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        priority if (pend_r) begin
          if (load_ok) begin
            emit      = 1'b1;
            emit_idx  = '0;
            emit_kind = KIND_ALL;
            emit_last = !any_ev;
            pend_nxt  = 1'b0;
          end
        end else if (ev[0] == EV_ON) begin
          if (load_ok) begin
            emit      = 1'b1;
            shift     = 1'b1;
            emit_idx  = NIDX_W'(idx_r);
            emit_kind = KIND_ONLINE;
            cnt_nxt   = cnt_r + CNT_W'(1);
            pend_nxt  = (cnt_nxt == node_cnt_ext);
            emit_last = !pend_nxt && !later_ev;
            idx_nxt   = idx_r + IDX_W'(1);
          end
        end else if (ev[0] == EV_LOST) begin
          if (load_ok) begin
            emit      = 1'b1;
            shift     = 1'b1;
            emit_idx  = NIDX_W'(idx_r);
            emit_kind = KIND_LOST;
            cnt_nxt   = cnt_r - CNT_W'(1);
            emit_last = !later_ev;
            idx_nxt   = idx_r + IDX_W'(1);
          end
        end else begin
          // Empty head slot: move the chain along; harmless once it is empty.
          shift   = 1'b1;
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_idx_r  <= emit_idx;
      out_kind_r <= emit_kind;
      out_last_r <= emit_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.node_index = out_idx_r;
  assign out_ch.event_kind = out_kind_r;
  assign out_ch.last_event = out_last_r;

endmodule

// ===== rtl/hpm_checker.sv =====
module hpm_checker import hpm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_op,
  input logic              out_valid,
  input logic              out_ready,
  input logic [NIDX_W-1:0] out_node_index,
  input logic [KIND_W-1:0] out_event_kind,
  input logic              out_last_event
);

  // A stalled event stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node_index) &&
      $stable(out_event_kind) && $stable(out_last_event))
    else $error("stalled event changed");

  // Only the three defined event kinds appear.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_kind == KIND_ONLINE) || (out_event_kind == KIND_LOST) ||
      (out_event_kind == KIND_ALL))
    else $error("undefined event kind");

  // The all-online event always reports node 0.
  a_all_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == KIND_ALL) |-> (out_node_index == '0))
    else $error("all-online event with nonzero node");

  // A receive request never produces an event.
  a_recv_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_RECV) |=> !$rose(out_valid))
    else $error("event after a receive request");

  // A check request blocks the input while its events are scanned.
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_CHECK) |=> !in_ready)
    else $error("input taken during a check scan");

endmodule

bind node_heartbeat_presence_monitor hpm_checker u_hpm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_op          (in_ch.op),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_node_index (out_ch.node_index),
  .out_event_kind (out_ch.event_kind),
  .out_last_event (out_ch.last_event)
);

// ===== tb/sv/tb_node_heartbeat_presence_monitor.sv =====
`timescale 1ns / 1ps

module tb_node_heartbeat_presence_monitor;
  import hpm_pkg::*;

  localparam int MAX_NODES     = (NODE_SLOTS_DEF < ADDR_REGS) ? NODE_SLOTS_DEF : ADDR_REGS;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 80;
  localparam int QUIET_LIMIT   = 1000;
  localparam int PRINT_CAP     = 100;

  // One presence event as seen on the result channel.
  typedef struct packed {
    logic [NIDX_W-1:0] node;
    logic [KIND_W-1:0] kind;
    logic              last;
  } presence_event_t;

  // Shadow of the monitor state and the queue of events it still owes.
  class presence_scoreboard;
    logic [ADDR_W-1:0] node_addr [ADDR_REGS];
    logic [NCNT_W-1:0] active_cfg;
    logic [TMO_W-1:0]  timeout_cfg;
    logic [TIME_W-1:0] heard_ms [NODE_SLOTS_DEF+1];
    bit                online [NODE_SLOTS_DEF];
    presence_event_t   events_due [$];
    int                mismatches;
    int                requests;
    int                checks;
    int                kind_seen [3];

    function new();
      for (int i = 0; i < ADDR_REGS; i++) node_addr[i] = ADDR_W'(i);
      active_cfg  = ACTIVE_NODES_RST;
      timeout_cfg = LOST_TIMEOUT_RST;
      foreach (heard_ms[i]) heard_ms[i] = '0;
      foreach (online[i]) online[i] = 1'b0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      mismatches = 0;
      requests   = 0;
      checks     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx <= REG_ADDR_NODE4) begin
        node_addr[idx] = data[ADDR_W-1:0];
      end else if (idx == REG_ACTIVE_NODES) begin
        active_cfg = data[NCNT_W-1:0];
      end else if (idx == REG_LOST_TIMEOUT) begin
        timeout_cfg = data[TMO_W-1:0];
      end
    endfunction

    // A node count of zero means one; anything above the slot count saturates.
    function int monitored();
      int n;
      n = active_cfg;
      if (n < 1) n = 1;
      if (n > MAX_NODES) n = MAX_NODES;
      return n;
    endfunction

    function int pending();
      return events_due.size();
    endfunction

    // Update the shadow state for one accepted request and queue its events.
    function void note_request(logic op, logic [ADDR_W-1:0] src, logic [TIME_W-1:0] now);
      int n;
      int slot;
      int on_count;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] limit;
      presence_event_t found [$];
      n     = monitored();
      limit = TIME_W'(timeout_cfg);
      requests++;
      if (op == OP_RECV) begin
        // Walk downward so the lowest matching active node wins.
        slot = NODE_SLOTS_DEF;
        for (int i = n - 1; i >= 0; i--) if (node_addr[i] == src) slot = i;
        heard_ms[slot] = now;
        return;
      end
      checks++;
      for (int i = 0; i < n; i++) begin
        elapsed = now - heard_ms[i];
        if (!online[i] && elapsed < limit && heard_ms[i] != '0) begin
          online[i] = 1'b1;
          found.push_back('{node: NIDX_W'(i), kind: KIND_ONLINE, last: 1'b0});
          on_count = 0;
          for (int j = 0; j < n; j++) on_count += online[j];
          if (on_count == n) found.push_back('{node: '0, kind: KIND_ALL, last: 1'b0});
        end else if (online[i] && elapsed > limit) begin
          online[i] = 1'b0;
          found.push_back('{node: NIDX_W'(i), kind: KIND_LOST, last: 1'b0});
        end
      end
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[k]) events_due.push_back(found[k]);
    endfunction

    // Printing stops after a cap so a broken run stays readable; counting goes on.
    task report(string msg);
      if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_event(logic [NIDX_W-1:0] node, logic [KIND_W-1:0] kind, logic last);
      presence_event_t want;
      if (events_due.size() == 0) begin
        report($sformatf("unexpected event node %0d kind %0d", node, kind));
        return;
      end
      want = events_due.pop_front();
      kind_seen[want.kind]++;
      if (node !== want.node)
        report($sformatf("node_index %0d, expected %0d", node, want.node));
      if (kind !== want.kind)
        report($sformatf("event_kind %0d, expected %0d (node %0d)", kind, want.kind, want.node));
      if (last !== want.last)
        report($sformatf("last_event %0b, expected %0b (node %0d)", last, want.last, want.node));
    endtask

    task flush_leftovers();
      presence_event_t want;
      while (events_due.size() > 0) begin
        want = events_due.pop_front();
        report($sformatf("event never arrived: node %0d kind %0d", want.node, want.kind));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  hpm_in_if  in_ch ();
  hpm_out_if out_ch ();
  hpm_cfg_if cfg_ch ();

  node_heartbeat_presence_monitor uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  presence_scoreboard sb = new();

  logic [TIME_W-1:0] clock_ms = '0;
  bit no_idle       = 1'b0;
  bit long_hold_req = 1'b0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Present one request and wait until the block takes it; valid stays high afterward.
  task automatic send_req(logic op, logic [ADDR_W-1:0] src, logic [TIME_W-1:0] now);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.op       = op;
    in_ch.src_addr = src;
    in_ch.now_ms   = now;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, src, now);
  endtask

  task automatic in_release();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Stop offering requests and wait until every owed event has arrived.
  task automatic wait_drained();
    in_release();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Drain, then give a trailing receive request time to finish before touching registers.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic apply_setting(logic [4:0][ADDR_W-1:0] addrs, logic [NCNT_W-1:0] count,
                               logic [TMO_W-1:0] tmo);
    for (int i = 0; i < ADDR_REGS; i++)
      cfg_write(REG_ADDR_NODE0 + CFG_IDX_W'(i), CFG_DAT_W'(addrs[i]));
    cfg_write(REG_ACTIVE_NODES, CFG_DAT_W'(count));
    cfg_write(REG_LOST_TIMEOUT, tmo);
    settings_used++;
  endtask

  // Heartbeats from mostly known nodes mixed with checks, with time stepping around
  // the timeout and an occasional jump to an arbitrary time.
  task automatic random_burst(int count, bit pause_mid);
    logic              op;
    logic [ADDR_W-1:0] src;
    int                pick;
    int unsigned       reach;
    for (int k = 0; k < count; k++) begin
      if (pause_mid && k == count / 2) wait_drained();
      reach = sb.timeout_cfg;
      op    = ($urandom_range(0, 99) < 35) ? OP_CHECK : OP_RECV;
      pick  = $urandom_range(0, 99);
      if (pick < 5)
        clock_ms = $urandom();
      else if (pick < 75)
        clock_ms += TIME_W'($urandom_range(0, reach / 2 + 2));
      else
        clock_ms += TIME_W'($urandom_range(0, 2 * reach + 10));
      if ($urandom_range(0, 4) == 0)
        src = ADDR_W'($urandom_range(0, 255));
      else
        src = sb.node_addr[$urandom_range(0, ADDR_REGS - 1)];
      send_req(op, src, clock_ms);
    end
  endtask

  // Directed requests under the reset register values.
  task automatic run_reset_directed();
    // A node heard at time zero never comes online.
    send_req(OP_RECV,  8'd0,   32'd0);
    send_req(OP_CHECK, 8'd0,   32'd10);
    // Elapsed equal to the timeout changes nothing; one less brings node 1 online.
    send_req(OP_RECV,  8'd1,   32'd1000);
    send_req(OP_CHECK, 8'd0,   32'd3000);
    send_req(OP_CHECK, 8'd0,   32'd2999);
    // An unknown address lands in the discard slot; node 1 is lost, node 2 comes online.
    send_req(OP_RECV,  8'd2,   32'd5000);
    send_req(OP_RECV,  8'd200, 32'd5000);
    send_req(OP_CHECK, 8'd0,   32'd5001);
    // An online node at exactly the timeout stays online.
    send_req(OP_RECV,  8'd1,   32'd6000);
    send_req(OP_CHECK, 8'd0,   32'd6000);
    send_req(OP_CHECK, 8'd0,   32'd7000);
    // Heartbeats just before the counter wraps, checked just after it.
    for (int i = 0; i < ADDR_REGS; i++) send_req(OP_RECV, ADDR_W'(i), 32'hFFFF_FF00);
    send_req(OP_CHECK, 8'd0,   32'h0000_0100);
    // Far in the future every node is lost.
    send_req(OP_CHECK, 8'hFF,  32'h7FFF_FFFF);
    clock_ms = 32'h7FFF_FFFF;
  endtask

  // Result side: random ready bursts, plus one long hold on request.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        hold--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD - 1;
        out_ch.ready = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 6);
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Check every accepted event against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_event(out_ch.node_index, out_ch.event_kind, out_ch.last_event);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    logic [4:0][ADDR_W-1:0] pick_addr;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_RECV;
    in_ch.src_addr = '0;
    in_ch.now_ms   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    rst_n          = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_reset_directed();

    // Widest settings: duplicate addresses, saturated node count, largest timeout.
    settle();
    apply_setting({8'h80, 8'h00, 8'h55, 8'h55, 8'hFF}, 3'd7, 16'hFFFF);
    send_req(OP_RECV,  8'h55, 32'd1000);
    send_req(OP_RECV,  8'h00, 32'd1000);
    send_req(OP_CHECK, 8'h00, 32'd1500);
    clock_ms = 32'd1500;
    random_burst(60, 1'b0);

    // Node count zero and a zero timeout; the sender drains halfway.
    settle();
    for (int i = 0; i < ADDR_REGS; i++) pick_addr[i] = ADDR_W'($urandom_range(0, 255));
    apply_setting(pick_addr, 3'd0, 16'd0);
    random_burst(40, 1'b1);

    // One node, timeout of one millisecond.
    settle();
    for (int i = 0; i < ADDR_REGS; i++) pick_addr[i] = ADDR_W'($urandom_range(0, 7));
    apply_setting(pick_addr, 3'd1, 16'd1);
    random_burst(50, 1'b0);

    // Mid-size setting with likely duplicates; the result side holds off for a long stretch.
    settle();
    for (int i = 0; i < ADDR_REGS; i++) pick_addr[i] = ADDR_W'($urandom_range(0, 7));
    apply_setting(pick_addr, NCNT_W'($urandom_range(2, 4)), TMO_W'($urandom_range(100, 4000)));
    long_hold_req = 1'b1;
    random_burst(60, 1'b1);

    // All five nodes with distinct addresses; all come back at once, then a final burst with no idle gaps.
    settle();
    apply_setting({8'h14, 8'h13, 8'h12, 8'h11, 8'h10}, 3'd5, 16'd2000);
    for (int i = 0; i < ADDR_REGS; i++) send_req(OP_RECV, 8'h10 + ADDR_W'(i), 32'hFFFF_FFFF);
    send_req(OP_CHECK, 8'h00, 32'd5);
    clock_ms = 32'd5;
    random_burst(30, 1'b0);
    no_idle = 1'b1;
    random_burst(40, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flush_leftovers();

    $display("Covered %0d requests (%0d status checks) over %0d register settings.",
             sb.requests, sb.checks, settings_used + 1);
    $display("Events checked: %0d online, %0d lost, %0d all-online.",
             sb.kind_seen[KIND_ONLINE], sb.kind_seen[KIND_LOST], sb.kind_seen[KIND_ALL]);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
